// File: hdl/linked_chunk_string_store_assert.svh
// Assertion macros shared by the linked chunk string store RTL
`ifndef LINKED_CHUNK_STRING_STORE_ASSERT_SVH
`define LINKED_CHUNK_STRING_STORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LCSS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LCSS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/lcss_pkg.sv
// Package: types, constants and helpers for the linked chunk string store
`timescale 1ns / 1ps
package lcss_pkg;
	localparam int ROWS       = 1024;
	localparam int MAX_CHUNKS = 64;
	localparam int ROW_W      = 11;
	localparam int AW         = $clog2(ROWS);
	localparam int CNT_W      = 7;
	localparam int DATA_W     = 64;

	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_INVALID = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_BROKEN  = 3'd3;
	localparam logic [2:0] ST_SEQ     = 3'd4;

	typedef struct packed {
		logic [1:0]        cmd;
		logic              first_chunk;
		logic [ROW_W-1:0]  row;
		logic [DATA_W-1:0] data_low;
		logic [DATA_W-1:0] data_high;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ROW_W-1:0]  result_row;
		logic [DATA_W-1:0] chunk_low;
		logic [DATA_W-1:0] chunk_high;
		logic              last;
	} out_item_t;

	function automatic logic row_ok(input logic [ROW_W-1:0] r);
		return (r != '0) && (r <= ROW_W'(ROWS));
	endfunction

	// 1-based row to memory address
	function automatic logic [AW-1:0] row_idx(input logic [ROW_W-1:0] r);
		logic [ROW_W-1:0] m;
		m = r - ROW_W'(1);
		return m[AW-1:0];
	endfunction
endpackage

// File: hdl/lcss_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module lcss_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/lcss_out_buf.sv
// Output register: holds one result so the controller can move on
`timescale 1ns / 1ps
module lcss_out_buf import lcss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      can_push,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	logic      valid_q;
	out_item_t data_q;

	assign can_push  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			data_q <= push_data;
		end
	end
endmodule

// File: hdl/linked_chunk_string_store.sv
// Linked chunk string store: usage
// Input channel in_valid/in_ready/in_data carries one command per transfer:
// write chunk, delete string, read string. Output channel out_valid/out_ready/
// out_data returns results; last marks the final result of a command.
// Strings live as doubly linked chains of 16-byte rows in link and chunk RAMs;
// free rows form a list. One command is worked at a time.
// A write chunk passes dispatch, a link read and two link writes before its
// result is queued in the output register; a write error goes from dispatch
// straight to its result. Delete and read walk the chain through the next-link
// RAM port, one row per cycle; a read then emits one chunk per cycle while the
// output register can take it. in_ready rises again in the cycle after the last
// result is queued. After reset the link RAMs are initialized by a sweep over
// every row, during which in_ready stays low.
// A stalled receiver holds the result in the output register; the block
// pauses its emission until that register frees up, and nothing is dropped.
`timescale 1ns / 1ps
module linked_chunk_string_store import lcss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);
	`include "linked_chunk_string_store_assert.svh"

	typedef enum logic [8:0] {
		S_CLEAR = 9'b000000001,
		S_IDLE  = 9'b000000010,
		S_DISP  = 9'b000000100,
		S_W1    = 9'b000001000,
		S_W2    = 9'b000010000,
		S_HEAD  = 9'b000100000,
		S_WALK  = 9'b001000000,
		S_EMIT  = 9'b010000000,
		S_RESP  = 9'b100000000
	} state_t;

	state_t            state_q, state_d;
	in_item_t          item_q;
	logic [AW-1:0]     clr_q;
	logic [ROW_W-1:0]  free_head_q, free_head_d;
	logic [ROW_W-1:0]  open_tail_q, open_tail_d;
	logic [CNT_W-1:0]  open_count_q, open_count_d;
	logic [ROW_W-1:0]  cur_q, cur_d;
	logic [ROW_W-1:0]  n_q, n_d;
	logic [ROW_W-1:0]  k_q, k_d;
	logic [ROW_W-1:0]  newfh_q, newfh_d;
	logic              has_open_q, has_open_d;
	out_item_t         res_q, res_d;

	// memory ports
	logic                nx_we, pv_we, ck_we;
	logic [AW-1:0]       nx_waddr, pv_waddr, ck_waddr;
	logic [ROW_W-1:0]    nx_wdata, pv_wdata;
	logic [2*DATA_W-1:0] ck_wdata, ck_rdata;
	logic [AW-1:0]       nx_raddr, pv_raddr, ck_raddr;
	logic [ROW_W-1:0]    nx_rdata, pv_rdata;

	logic      push, can_push;
	out_item_t push_data;

	// walk step
	logic [ROW_W-1:0] w_cur, w_n, pre;
	logic             w_ho;
	logic             emit_last;

	lcss_ram #(.W(ROW_W), .D(ROWS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
		.raddr(nx_raddr), .rdata(nx_rdata)
	);

	lcss_ram #(.W(ROW_W), .D(ROWS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
		.raddr(pv_raddr), .rdata(pv_rdata)
	);

	lcss_ram #(.W(2 * DATA_W), .D(ROWS)) u_chunk (
		.clk(clk), .we(ck_we), .waddr(ck_waddr), .wdata(ck_wdata),
		.raddr(ck_raddr), .rdata(ck_rdata)
	);

	lcss_out_buf u_out (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.can_push(can_push), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign pre       = item_q.first_chunk ? '0 : open_tail_q;
	assign w_cur     = (state_q == S_HEAD) ? item_q.row : cur_q;
	assign w_n       = (state_q == S_HEAD) ? ROW_W'(1) : n_q;
	assign w_ho      = ((state_q == S_HEAD) ? 1'b0 : has_open_q) ||
		(open_tail_q != '0 && w_cur == open_tail_q);
	assign emit_last = (k_q == n_q - ROW_W'(1));

	function automatic out_item_t err_res(input logic [2:0] st);
		out_item_t r;
		r            = '0;
		r.status     = st;
		r.last       = 1'b1;
		return r;
	endfunction

	always_comb begin
		state_d      = state_q;
		free_head_d  = free_head_q;
		open_tail_d  = open_tail_q;
		open_count_d = open_count_q;
		cur_d        = cur_q;
		n_d          = n_q;
		k_d          = k_q;
		newfh_d      = newfh_q;
		has_open_d   = has_open_q;
		res_d        = res_q;
		nx_we        = 1'b0;
		pv_we        = 1'b0;
		ck_we        = 1'b0;
		nx_waddr     = row_idx(cur_q);
		pv_waddr     = row_idx(cur_q);
		ck_waddr     = row_idx(free_head_q);
		nx_wdata     = '0;
		pv_wdata     = '0;
		ck_wdata     = {item_q.data_high, item_q.data_low};
		nx_raddr     = row_idx(cur_q);
		pv_raddr     = row_idx(item_q.row);
		ck_raddr     = row_idx(cur_q);
		push         = 1'b0;
		push_data    = res_q;

		unique case (state_q)
			S_CLEAR: begin
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				nx_waddr = clr_q;
				pv_waddr = clr_q;
				nx_wdata = ROW_W'(clr_q) + ROW_W'(2);
				pv_wdata = ROW_W'(clr_q);
				if (clr_q == AW'(ROWS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (item_q.cmd)
					CMD_WRITE: begin
						if (!item_q.first_chunk && (open_tail_q == '0 ||
							!row_ok(open_tail_q) ||
							open_count_q >= CNT_W'(MAX_CHUNKS))) begin
							res_d   = err_res(ST_SEQ);
							state_d = S_RESP;
						end else if (!row_ok(free_head_q)) begin
							res_d   = err_res(ST_FULL);
							state_d = S_RESP;
						end else begin
							nx_raddr = row_idx(free_head_q);
							state_d  = S_W1;
						end
					end
					CMD_DELETE, CMD_READ: begin
						if (!row_ok(item_q.row) || item_q.row == free_head_q) begin
							res_d   = err_res(ST_INVALID);
							state_d = S_RESP;
						end else begin
							nx_raddr = row_idx(item_q.row);
							state_d  = S_HEAD;
						end
					end
					default: begin
						res_d   = err_res(ST_SEQ);
						state_d = S_RESP;
					end
				endcase
			end
			S_W1: begin
				nx_we    = 1'b1;
				pv_we    = 1'b1;
				ck_we    = 1'b1;
				nx_waddr = row_idx(free_head_q);
				pv_waddr = row_idx(free_head_q);
				nx_wdata = '0;
				pv_wdata = pre;
				newfh_d  = nx_rdata;
				state_d  = S_W2;
			end
			S_W2: begin
				nx_we        = (pre != '0);
				nx_waddr     = row_idx(pre);
				nx_wdata     = free_head_q;
				// no back link when the last free row was taken
				pv_we        = row_ok(newfh_q);
				pv_waddr     = row_idx(newfh_q);
				pv_wdata     = '0;
				free_head_d  = newfh_q;
				open_tail_d  = free_head_q;
				open_count_d = item_q.first_chunk ? CNT_W'(1) : open_count_q + CNT_W'(1);
				res_d            = '0;
				res_d.status     = ST_OK;
				res_d.result_row = free_head_q;
				res_d.last       = 1'b1;
				state_d          = S_RESP;
			end
			S_HEAD, S_WALK: begin
				if (state_q == S_HEAD && pv_rdata != '0) begin
					res_d   = err_res(ST_INVALID);
					state_d = S_RESP;
				end else if (nx_rdata == '0) begin
					// w_cur is the tail, w_n the length
					if (item_q.cmd == CMD_DELETE) begin
						nx_we    = 1'b1;
						nx_waddr = row_idx(w_cur);
						nx_wdata = free_head_q;
						pv_we    = row_ok(free_head_q);
						pv_waddr = row_idx(free_head_q);
						pv_wdata = w_cur;
						free_head_d = item_q.row;
						if (w_ho) begin
							open_tail_d  = '0;
							open_count_d = '0;
						end
						res_d            = '0;
						res_d.status     = ST_OK;
						res_d.result_row = item_q.row;
						res_d.last       = 1'b1;
						state_d          = S_RESP;
					end else if (w_n > ROW_W'(MAX_CHUNKS)) begin
						res_d   = err_res(ST_SEQ);
						state_d = S_RESP;
					end else begin
						n_d      = w_n;
						cur_d    = item_q.row;
						k_d      = '0;
						nx_raddr = row_idx(item_q.row);
						ck_raddr = row_idx(item_q.row);
						state_d  = S_EMIT;
					end
				end else if (nx_rdata > ROW_W'(ROWS) || w_n >= ROW_W'(ROWS)) begin
					res_d   = err_res(ST_BROKEN);
					state_d = S_RESP;
				end else begin
					cur_d      = nx_rdata;
					n_d        = w_n + ROW_W'(1);
					has_open_d = w_ho;
					nx_raddr   = row_idx(nx_rdata);
					state_d    = S_WALK;
				end
			end
			S_EMIT: begin
				push_data            = '0;
				push_data.status     = ST_OK;
				push_data.result_row = cur_q;
				push_data.chunk_low  = ck_rdata[DATA_W-1:0];
				push_data.chunk_high = ck_rdata[2*DATA_W-1:DATA_W];
				push_data.last       = emit_last;
				if (can_push) begin
					push = 1'b1;
					if (emit_last) begin
						state_d = S_IDLE;
					end else begin
						cur_d    = nx_rdata;
						k_d      = k_q + ROW_W'(1);
						nx_raddr = row_idx(nx_rdata);
						ck_raddr = row_idx(nx_rdata);
					end
				end
			end
			S_RESP: begin
				if (can_push) begin
					push    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			free_head_q  <= ROW_W'(1);
			open_tail_q  <= '0;
			open_count_q <= '0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_q + AW'(1);
			free_head_q  <= free_head_d;
			open_tail_q  <= open_tail_d;
			open_count_q <= open_count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= in_data;
		end
		cur_q      <= cur_d;
		n_q        <= n_d;
		k_q        <= k_d;
		newfh_q    <= newfh_d;
		has_open_q <= has_open_d;
		res_q      <= res_d;
	end

	`LCSS_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q), "state not one-hot")
	`LCSS_ASSERT_NEXT(a_accept_disp, in_valid && in_ready, state_q == S_DISP,
		"accepted transfer did not reach dispatch")
	`LCSS_ASSERT_NOW(a_open_pair, 1'b1, (open_tail_q == '0) == (open_count_q == '0),
		"open tail and open count disagree")
	`LCSS_ASSERT_NOW(a_emit_range, state_q == S_EMIT, k_q < n_q && n_q <= ROW_W'(MAX_CHUNKS),
		"read emission beyond chain length")
endmodule
